// File: rtl/pdcs_pkg.sv
package pdcs_pkg;

    localparam int CMD_BYTE_W  = 8;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [15:0] UNIT_CYCLES_RST     = 16'd833;
    localparam logic [7:0]  START_UNITS_RST     = 8'd8;
    localparam logic [7:0]  ZERO_HIGH_UNITS_RST = 8'd1;
    localparam logic [7:0]  ONE_HIGH_UNITS_RST  = 8'd4;
    localparam logic [7:0]  LOW_UNITS_RST       = 8'd1;
    localparam logic        MARK_ENABLE_RST     = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [CMD_BYTE_W-1:0] command_byte;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic bit_strobe;
        logic mark_level;
        logic busy_res;
        logic done_res;
        logic rejected;
    } result_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SEND = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [CMD_BYTE_W-1:0] command_byte;
    } cmd_t;

    typedef struct packed {
        logic [15:0] unit_cycles;
        logic [7:0]  start_units;
        logic [7:0]  zero_high_units;
        logic [7:0]  one_high_units;
        logic [7:0]  low_units;
        logic        mark_enable;
    } cfg_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_HIGH  = 4'b0100,
        PH_LOW   = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        REG_UNIT_CYCLES     = 3'd0,
        REG_START_UNITS     = 3'd1,
        REG_ZERO_HIGH_UNITS = 3'd2,
        REG_ONE_HIGH_UNITS  = 3'd3,
        REG_LOW_UNITS       = 3'd4,
        REG_MARK_ENABLE     = 3'd5
    } reg_index_t;

endpackage

// File: rtl/pdcs_front.sv
module pdcs_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  pdcs_pkg::item_t item,
    output logic           cmd_valid,
    output pdcs_pkg::cmd_t cmd,
    input  logic           cmd_pop
);
    import pdcs_pkg::*;

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    cmd_t              cmd_in;
    logic              push;

    // classify the incoming beat
    always_comb
    begin
        cmd_in.kind         = item.kind ? CMD_SEND : CMD_TICK;
        cmd_in.command_byte = item.command_byte;
    end

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid & ~item_stall;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (cmd_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: rtl/pdcs_back.sv
module pdcs_back #(
    parameter int DATA_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pdcs_pkg::cfg_t    cfg,
    input  logic              cmd_valid,
    input  pdcs_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output pdcs_pkg::result_t result
);
    import pdcs_pkg::*;

    localparam int BL_W = $clog2(DATA_BITS + 1);
    localparam logic [BL_W-1:0] BITS_FULL = BL_W'(DATA_BITS);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [DATA_BITS-1:0]  shift_reg;
    logic [DATA_BITS-1:0]  shift_next;
    logic [BL_W-1:0]       bits_left_reg;
    logic [BL_W-1:0]       bits_left_next;
    logic [BL_W-1:0]       bits_dec;
    logic [7:0]            unit_count_reg;
    logic [7:0]            unit_count_next;
    logic [15:0]           prescale_reg;
    logic [15:0]           prescale_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    result_t               result_reg;
    result_t               result_next;
    logic [DATA_BITS-1:0]  load_word;
    logic [7:0]            seg_units;
    logic                  done;
    logic                  rej;
    logic                  busy;

    for (genvar i = 0; i < DATA_BITS; i++)
    begin : g_load
        if (i < CMD_BYTE_W)
        begin : g_bit
            assign load_word[i] = cmd.command_byte[i];
        end
        else
        begin : g_pad
            assign load_word[i] = 1'b0;
        end
    end

    assign cmd_pop = cmd_valid & (~result_valid_reg | ~result_stall);
    assign bits_dec = (bits_left_reg != '0) ? bits_left_reg - BL_W'(1) : '0;

    always_comb
    begin
        case (phase_reg)
            PH_START: seg_units = cfg.start_units;
            PH_HIGH:  seg_units = shift_reg[DATA_BITS-1] ? cfg.one_high_units
                                                         : cfg.zero_high_units;
            PH_LOW:   seg_units = cfg.low_units;
            default:  seg_units = 8'd1;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        bits_left_next  = bits_left_reg;
        unit_count_next = unit_count_reg;
        prescale_next   = prescale_reg;
        done            = 1'b0;
        rej             = 1'b0;
        if (cmd.kind == CMD_SEND)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                shift_next      = load_word;
                bits_left_next  = BITS_FULL;
                unit_count_next = '0;
                prescale_next   = '0;
                phase_next      = PH_START;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (({1'b0, prescale_reg} + 17'd1) < {1'b0, cfg.unit_cycles})
            begin
                prescale_next = prescale_reg + 16'd1;
            end
            else
            begin
                prescale_next = '0;
                if (({1'b0, unit_count_reg} + 9'd1) < {1'b0, seg_units})
                begin
                    unit_count_next = unit_count_reg + 8'd1;
                end
                else
                begin
                    unit_count_next = '0;
                    case (phase_reg)
                        PH_START:
                        begin
                            phase_next     = PH_HIGH;
                            bits_left_next = BITS_FULL;
                        end
                        PH_HIGH:
                        begin
                            phase_next = PH_LOW;
                        end
                        default:
                        begin
                            shift_next     = shift_reg << 1;
                            bits_left_next = bits_dec;
                            if (bits_dec == '0)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_HIGH;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        busy                   = (phase_next != PH_IDLE);
        result_next.line_level = (phase_next inside {PH_IDLE, PH_HIGH});
        result_next.bit_strobe = (phase_next inside {PH_HIGH, PH_LOW});
        result_next.mark_level = busy & cfg.mark_enable;
        result_next.busy_res   = busy;
        result_next.done_res   = done;
        result_next.rejected   = rej;
    end

    assign result_valid_next = cmd_pop | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            shift_reg        <= '0;
            bits_left_reg    <= '0;
            unit_count_reg   <= '0;
            prescale_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (cmd_pop)
            begin
                phase_reg      <= phase_next;
                shift_reg      <= shift_next;
                bits_left_reg  <= bits_left_next;
                unit_count_reg <= unit_count_next;
                prescale_reg   <= prescale_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/pulse_distance_command_sender_unit.sv
// Pulse-distance command sender.
// Item channel (item_valid / item_stall / item): each beat is either a time
// tick (kind 0) or a request to send command_byte (kind 1). A send request
// arms the frame; ticks then drive the start pulse and the DATA_BITS data
// bits, most significant first. A request while a frame runs is dropped and
// flagged in its result.
// Result channel (result_valid / result_stall / result): exactly one beat per
// item beat, in order, giving the line level, bit strobe, envelope mark,
// busy, done and rejected flags after that item.
// Throughput: one item per cycle while the receiver does not stall results. An
// accepted item is written into the two-beat command queue, then moves
// through the sequencer into the result register once that register is free.
// When the receiver stalls, the result register holds its beat, the queue
// fills, and item_stall rises once it holds two beats.
// Reset clears queue and sequencer (line idle high), loads timing registers
// with defaults; the APB port writes them only while idle (user rule, not enforced).
module pulse_distance_command_sender_unit #(
    parameter int DATA_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  pdcs_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output pdcs_pkg::result_t                   result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pdcs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pdcs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pdcs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import pdcs_pkg::*;

    cfg_t           cfg_reg;
    cfg_t           cfg_next;
    reg_index_t     reg_index;
    logic           wr_en;
    logic           cmd_valid;
    logic           cmd_pop;
    cmd_t           cmd;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_UNIT_CYCLES:     cfg_next.unit_cycles     = pwdata[15:0];
                REG_START_UNITS:     cfg_next.start_units     = pwdata[7:0];
                REG_ZERO_HIGH_UNITS: cfg_next.zero_high_units = pwdata[7:0];
                REG_ONE_HIGH_UNITS:  cfg_next.one_high_units  = pwdata[7:0];
                REG_LOW_UNITS:       cfg_next.low_units       = pwdata[7:0];
                REG_MARK_ENABLE:     cfg_next.mark_enable     = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_UNIT_CYCLES:     prdata = APB_DATA_W'(cfg_reg.unit_cycles);
            REG_START_UNITS:     prdata = APB_DATA_W'(cfg_reg.start_units);
            REG_ZERO_HIGH_UNITS: prdata = APB_DATA_W'(cfg_reg.zero_high_units);
            REG_ONE_HIGH_UNITS:  prdata = APB_DATA_W'(cfg_reg.one_high_units);
            REG_LOW_UNITS:       prdata = APB_DATA_W'(cfg_reg.low_units);
            REG_MARK_ENABLE:     prdata = APB_DATA_W'(cfg_reg.mark_enable);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_cycles     <= UNIT_CYCLES_RST;
            cfg_reg.start_units     <= START_UNITS_RST;
            cfg_reg.zero_high_units <= ZERO_HIGH_UNITS_RST;
            cfg_reg.one_high_units  <= ONE_HIGH_UNITS_RST;
            cfg_reg.low_units       <= LOW_UNITS_RST;
            cfg_reg.mark_enable     <= MARK_ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pdcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    pdcs_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pdcs_pkg::*;

    localparam int DATA_BITS   = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_WAIT = 4;
    localparam int TAIL_WAIT   = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_t                  timing_cfg;
    phase_t                seq_phase;
    logic [DATA_BITS-1:0]  shift_q;
    logic [3:0]            bits_left_q;
    logic [7:0]            unit_q;
    logic [15:0]           prescale_q;

    result_t               expected_results[$];
    int                    fail_count = 0;
    int                    quiet_cycles = 0;
    bit                    tx_gaps_on = 1'b1;
    bit                    rx_gaps_on = 1'b1;
    int                    rx_hold_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pulse_distance_command_sender_unit #(
        .DATA_BITS(DATA_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    function automatic logic [7:0] segment_units();
        case (seq_phase)
            PH_START: return timing_cfg.start_units;
            PH_HIGH:  return shift_q[DATA_BITS-1] ? timing_cfg.one_high_units
                                                  : timing_cfg.zero_high_units;
            PH_LOW:   return timing_cfg.low_units;
            default:  return 8'd1;
        endcase
    endfunction

    function automatic logic advance_tick();
        if (seq_phase == PH_IDLE)
        begin
            return 1'b0;
        end
        if ({1'b0, prescale_q} + 17'd1 < {1'b0, timing_cfg.unit_cycles})
        begin
            prescale_q = prescale_q + 16'd1;
            return 1'b0;
        end
        prescale_q = '0;
        if ({1'b0, unit_q} + 9'd1 < {1'b0, segment_units()})
        begin
            unit_q = unit_q + 8'd1;
            return 1'b0;
        end
        unit_q = '0;
        case (seq_phase)
            PH_START:
            begin
                seq_phase   = PH_HIGH;
                bits_left_q = 4'(DATA_BITS);
            end
            PH_HIGH:
            begin
                seq_phase = PH_LOW;
            end
            default:
            begin
                shift_q = shift_q << 1;
                if (bits_left_q != 4'd0)
                begin
                    bits_left_q = bits_left_q - 4'd1;
                end
                if (bits_left_q == 4'd0)
                begin
                    seq_phase = PH_IDLE;
                    return 1'b1;
                end
                seq_phase = PH_HIGH;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic result_t line_after_item(input item_t it);
        result_t r;
        r = '0;
        if (it.kind == CMD_TICK)
        begin
            r.done_res = advance_tick();
        end
        else if (seq_phase != PH_IDLE)
        begin
            r.rejected = 1'b1;
        end
        else
        begin
            shift_q     = it.command_byte[DATA_BITS-1:0];
            bits_left_q = 4'(DATA_BITS);
            unit_q      = '0;
            prescale_q  = '0;
            seq_phase   = PH_START;
        end
        r.busy_res   = (seq_phase != PH_IDLE);
        r.line_level = (seq_phase == PH_IDLE) || (seq_phase == PH_HIGH);
        r.bit_strobe = (seq_phase == PH_HIGH) || (seq_phase == PH_LOW);
        r.mark_level = r.busy_res && timing_cfg.mark_enable;
        return r;
    endfunction

    task automatic send_item(input cmd_kind_t k, input logic [7:0] b);
        int    gap;
        item_t it;
        gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
        it.kind         = k;
        it.command_byte = b;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        expected_results.push_back(line_after_item(it));
    endtask

    task automatic stop_items();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task automatic settle();
        stop_items();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic finish_frame();
        bit saved_gaps;
        saved_gaps = tx_gaps_on;
        tx_gaps_on = 1'b0;
        while (seq_phase != PH_IDLE) send_item(CMD_TICK, 8'($urandom));
        tx_gaps_on = saved_gaps;
        settle();
    endtask

    task automatic check_reg(input reg_index_t idx, input logic [31:0] want);
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(idx) << 2;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            $display("%0t: register %s readback mismatch, expected %h, actual %h",
                     $time, idx.name(), want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        case (idx)
            REG_UNIT_CYCLES:     timing_cfg.unit_cycles     = val[15:0];
            REG_START_UNITS:     timing_cfg.start_units     = val[7:0];
            REG_ZERO_HIGH_UNITS: timing_cfg.zero_high_units = val[7:0];
            REG_ONE_HIGH_UNITS:  timing_cfg.one_high_units  = val[7:0];
            REG_LOW_UNITS:       timing_cfg.low_units       = val[7:0];
            default:             timing_cfg.mark_enable     = val[0];
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_reg(idx, val);
    endtask

    task automatic set_timing(input logic [15:0] uc, input logic [7:0] su,
                              input logic [7:0] zh, input logic [7:0] oh,
                              input logic [7:0] lu, input logic me);
        write_reg(REG_UNIT_CYCLES, 32'(uc));
        write_reg(REG_START_UNITS, 32'(su));
        write_reg(REG_ZERO_HIGH_UNITS, 32'(zh));
        write_reg(REG_ONE_HIGH_UNITS, 32'(oh));
        write_reg(REG_LOW_UNITS, 32'(lu));
        write_reg(REG_MARK_ENABLE, 32'(me));
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic test_reset_values();
        check_reg(REG_UNIT_CYCLES, 32'(UNIT_CYCLES_RST));
        check_reg(REG_START_UNITS, 32'(START_UNITS_RST));
        check_reg(REG_ZERO_HIGH_UNITS, 32'(ZERO_HIGH_UNITS_RST));
        check_reg(REG_ONE_HIGH_UNITS, 32'(ONE_HIGH_UNITS_RST));
        check_reg(REG_LOW_UNITS, 32'(LOW_UNITS_RST));
        check_reg(REG_MARK_ENABLE, 32'(MARK_ENABLE_RST));
    endtask

    task automatic test_default_frame();
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_SEND, 8'h5A);
        send_item(CMD_SEND, 8'hFF);
        repeat (4) send_item(CMD_TICK, 8'h00);
        settle();
        set_timing(16'd1, 8'd1, 8'd1, 8'd2, 8'd1, 1'b1);
        finish_frame();
        send_item(CMD_TICK, 8'h00);
        settle();
    endtask

    task automatic test_zero_registers();
        set_timing(16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_SEND, 8'hC3);
        send_item(CMD_SEND, 8'h3C);
        finish_frame();
        send_item(CMD_SEND, 8'h00);
        repeat (5) send_item(CMD_TICK, 8'hFF);
        send_item(CMD_SEND, 8'hFF);
        finish_frame();
    endtask

    task automatic test_unit_extremes();
        set_timing(16'd1, 8'd1, 8'd1, 8'd255, 8'd1, 1'b1);
        send_item(CMD_SEND, 8'h80);
        finish_frame();
        set_timing(16'd2, 8'd1, 8'd1, 8'd1, 8'd1, 1'b0);
        send_item(CMD_SEND, 8'hFF);
        send_item(CMD_SEND, 8'h00);
        finish_frame();
        send_item(CMD_SEND, 8'h01);
        finish_frame();
    endtask

    task automatic test_random_phases();
        int          roll;
        logic [7:0]  units[4];
        for (int p = 0; p < 4; p++)
        begin
            for (int u = 0; u < 4; u++)
            begin
                units[u] = 8'($urandom_range(0, 4));
            end
            set_timing(16'($urandom_range(0, 3)), units[0], units[1], units[2], units[3],
                       1'($urandom_range(0, 1)));
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 50; i++)
            begin
                roll = $urandom_range(0, 99);
                if (seq_phase == PH_IDLE && roll < 60)
                begin
                    send_item(CMD_SEND, 8'($urandom));
                end
                else if (seq_phase != PH_IDLE && roll < 5)
                begin
                    send_item(CMD_SEND, 8'($urandom));
                end
                else
                begin
                    send_item(CMD_TICK, 8'($urandom));
                end
            end
            finish_frame();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_timing(16'd1, 8'd2, 8'd1, 8'd3, 8'd1, 1'b1);
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = 300;
        send_item(CMD_SEND, 8'($urandom));
        for (int i = 0; i < 60; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(CMD_SEND, 8'($urandom));
            end
            else
            begin
                send_item(CMD_TICK, 8'($urandom));
            end
        end
        finish_frame();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_long_unit();
        set_timing(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_SEND, 8'($urandom));
        for (int i = 0; i < 60; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(CMD_SEND, 8'($urandom));
            end
            else
            begin
                send_item(CMD_TICK, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = rx_gaps_on ? $urandom_range(0, 5) : 0;
            if (rx_hold_cycles > 0)
            begin
                n              = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            @(negedge clk);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, actual %b",
                         $time, result);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("line_level", want.line_level, result.line_level);
                check_field("bit_strobe", want.bit_strobe, result.bit_strobe);
                check_field("mark_level", want.mark_level, result.mark_level);
                check_field("busy_res", want.busy_res, result.busy_res);
                check_field("done_res", want.done_res, result.done_res);
                check_field("rejected", want.rejected, result.rejected);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("pulse_distance_command_sender_unit test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        timing_cfg.unit_cycles     = UNIT_CYCLES_RST;
        timing_cfg.start_units     = START_UNITS_RST;
        timing_cfg.zero_high_units = ZERO_HIGH_UNITS_RST;
        timing_cfg.one_high_units  = ONE_HIGH_UNITS_RST;
        timing_cfg.low_units       = LOW_UNITS_RST;
        timing_cfg.mark_enable     = MARK_ENABLE_RST;
        seq_phase   = PH_IDLE;
        shift_q     = '0;
        bits_left_q = '0;
        unit_q      = '0;
        prescale_q  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_default_frame();
        test_zero_registers();
        test_unit_extremes();
        test_random_phases();
        test_backpressure();
        test_long_unit();

        stop_items();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("pulse_distance_command_sender_unit test passed");
        end
        else
        begin
            $display("pulse_distance_command_sender_unit test failed");
        end
        $finish;
    end

endmodule

// File: pulse_distance_command_sender_unit.f
rtl/pdcs_pkg.sv
rtl/pdcs_front.sv
rtl/pdcs_back.sv
rtl/pulse_distance_command_sender_unit.sv
tb/sv/tb_top.sv
